>>> rtl/core/fcd_pkg.sv
// Shared constants, command/status types and the CRC-8 step for the frame deframer.
package fcd_pkg;

  localparam int unsigned FRAME_LEN = 15;
  localparam int unsigned LAST_PAY  = FRAME_LEN - 2;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int unsigned OUT_IDX_W = 6;

  localparam logic [7:0] START_MARK = 8'hdd;
  localparam logic [7:0] CRC_INIT   = 8'h00;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  typedef struct packed {
    logic shift;
    logic idx_init;
    logic crc_step;
    logic fill_clr;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic marker_ok;
    logic crc_match;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/fcd_datapath.sv
// Datapath: byte window, fill count, CRC accumulator, read index and output register.
module fcd_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  fcd_pkg::ctl_cmd_t cmd,
  output fcd_pkg::dp_stat_t st,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_payload_byte,
  output logic [5:0]       out_byte_index,
  output logic             out_last
);
  import fcd_pkg::*;

  logic [7:0]           window_r [FRAME_LEN];
  logic [FILL_W-1:0]    fill_r;
  logic [7:0]           crc_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic                 out_last_r;
  logic [7:0]           rd_byte;
  logic                 idx_last;

  assign rd_byte  = window_r[idx_r];
  assign idx_last = (idx_r == IDX_W'(LAST_PAY));

  // Slide the window towards the oldest end.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[FRAME_LEN-1] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clr) begin
      fill_r <= '0;
    end else if (cmd.shift && (fill_r != FILL_W'(FRAME_LEN))) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_init) begin
      idx_r <= IDX_W'(1);
      crc_r <= CRC_INIT;
    end else if (cmd.crc_step) begin
      crc_r <= crc8_byte(crc_r, rd_byte);
      idx_r <= idx_r + IDX_W'(1);
    end else if (cmd.emit_load) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_byte_r <= rd_byte;
      out_idx_r  <= OUT_IDX_W'(idx_r - IDX_W'(1));
      out_last_r <= idx_last;
    end
  end

  assign st.fill_full = (fill_r == FILL_W'(FRAME_LEN));
  assign st.marker_ok = (window_r[0] == START_MARK);
  assign st.crc_match = (crc_r == window_r[FRAME_LEN-1]);
  assign st.idx_last  = idx_last;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_last         = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten while stalled");

  a_clear_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_clr |-> (fill_r == FILL_W'(FRAME_LEN)))
    else $error("frame accepted without a full window");

  a_crc_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crc_step |-> ((idx_r >= IDX_W'(1)) && (idx_r <= IDX_W'(LAST_PAY))))
    else $error("CRC read outside the payload");

endmodule

>>> rtl/core/fcd_ctrl.sv
// Controller: sequences byte intake, frame test, CRC pass, check and payload emission.
module fcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcd_pkg::dp_stat_t st,
  output fcd_pkg::ctl_cmd_t cmd
);
  import fcd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TEST  = 3'd1;
  localparam logic [2:0] ST_CRC   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (st.fill_full && st.marker_ok) begin
          cmd.idx_init = 1'b1;
          state_nxt    = ST_CRC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CRC: begin
        cmd.crc_step = 1'b1;
        if (st.idx_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.crc_match) begin
          cmd.fill_clr = 1'b1;
          cmd.idx_init = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.idx_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_crc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRC) |=> ((state_r == ST_CRC) || (state_r == ST_CHECK)))
    else $error("CRC pass left early");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !st.out_free) |=> (state_r == ST_EMIT))
    else $error("emission abandoned while output stalled");

endmodule

>>> rtl/core/fixed_frame_crc8_deframer.sv
// Top level of the fixed-length frame deframer with CRC-8 check.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_rx_byte[7:0]            | word in
//  out     | out_valid, out_ready, out_payload_byte[7:0],   | word out
//          | out_byte_index[5:0], out_last                  |
//
// Each received word passes through intake and a frame test when no frame
// starts at the oldest window byte. A candidate frame adds a byte-serial CRC
// pass over the FRAME_LEN-2 body bytes through the single window read port,
// a check step, then emission of FRAME_LEN-2 payload words.
// Reset (rst_n low, synchronous) clears the fill count, state and output
// valid; window contents are left as they are and never read before being
// written. An output stall holds the emission; intake waits until it ends.
module fixed_frame_crc8_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);
  import fcd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  // Controller: decide when to shift, check and emit.
  fcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: hold the window, advance the CRC, drive the output word.
  fcd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

>>> tb/fixed_frame_crc8_deframer_chk.sv
// Checker for the frame deframer: tracks the receive window, predicts payload words, compares.
module fixed_frame_crc8_deframer_chk (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_payload_byte,
  input  logic [5:0] out_byte_index,
  input  logic       out_last,
  output int         mismatches,
  output int         words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcd_pkg::*;

  typedef struct packed {
    logic [7:0]           data;
    logic [OUT_IDX_W-1:0] idx;
    logic                 last;
  } pay_word_t;

  pay_word_t   payload_due[$];
  logic [7:0]  rx_win [FRAME_LEN];
  int unsigned fill;

  // bit-serial CRC over the bytes between marker and check byte
  function automatic logic [7:0] body_crc();
    logic [7:0] r;
    logic       fb;
    r = CRC_INIT;
    for (int i = 1; i < FRAME_LEN - 1; i++) begin
      for (int b = 7; b >= 0; b--) begin
        fb = r[7] ^ rx_win[i][b];
        r  = {r[6:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // slide one byte into the window and queue the payload if a frame closes
  task automatic take_rx_byte(input logic [7:0] b);
    pay_word_t w;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      rx_win[i] = rx_win[i + 1];
    end
    rx_win[FRAME_LEN - 1] = b;
    if (fill < FRAME_LEN) begin
      fill++;
    end
    if (fill == FRAME_LEN && rx_win[0] == START_MARK && body_crc() == rx_win[FRAME_LEN - 1]) begin
      for (int i = 0; i < LAST_PAY; i++) begin
        w.data = rx_win[i + 1];
        w.idx  = OUT_IDX_W'(i);
        w.last = (i == LAST_PAY - 1);
        payload_due.push_back(w);
      end
      fill = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    pay_word_t w;
    if (!rst_n) begin
      fill       = 0;
      mismatches = 0;
      payload_due.delete();
      foreach (rx_win[i]) begin
        rx_win[i] = 8'h00;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (payload_due.size() == 0) begin
          flag_mismatch($sformatf("payload word 0x%02h index %0d with no frame accepted",
                                  out_payload_byte, out_byte_index));
        end else begin
          w = payload_due.pop_front();
          if (out_payload_byte !== w.data) begin
            flag_mismatch($sformatf("payload_byte 0x%02h, want 0x%02h (index %0d)",
                                    out_payload_byte, w.data, w.idx));
          end
          if (out_byte_index !== w.idx) begin
            flag_mismatch($sformatf("byte_index %0d, want %0d", out_byte_index, w.idx));
          end
          if (out_last !== w.last) begin
            flag_mismatch($sformatf("last %0b, want %0b (index %0d)", out_last, w.last, w.idx));
          end
        end
      end
      if (in_valid && in_ready) begin
        take_rx_byte(in_rx_byte);
      end
    end
    words_due <= payload_due.size();
  end

endmodule

>>> tb/fixed_frame_crc8_deframer_tb.sv
// Top of the deframer testbench: clock, reset, byte stimulus, output stalls and verdict.
module fixed_frame_crc8_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcd_pkg::*;

  localparam int N_ITEMS     = 380;
  // the longest output stall on top of a frame pass is the worst
  // stretch without any word moving; allow many times that
  localparam int WD_LIMIT    = 3000;
  // a byte that closes no frame still passes through intake and frame test inside
  localparam int TAIL_CYCLES = 2 * FRAME_LEN + 4;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_last;

  int         mismatches;
  int         words_due;
  int         sent = 0;
  // calm stretches: no gaps on either side while set
  logic       calm = 1'b0;
  int         stall_left = 0;
  logic [7:0] frame_body [LAST_PAY];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_frame_crc8_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

  fixed_frame_crc8_deframer_chk i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .words_due        (words_due)
  );

  // Receiver side: stall out_ready for random stretches, mostly short, now and
  // then long, and drop into a calm stretch from time to time so that runs of
  // back-to-back words appear as well.
  always @(negedge clk) begin : sink_stalls
    int r;
    if ($urandom_range(0, 249) == 0) begin
      calm <= !calm;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
      end else begin
        if (r < 88) begin
          stall_left = $urandom_range(1, 3);
        end else if (r < 98) begin
          stall_left = $urandom_range(4, 12);
        end else begin
          stall_left = $urandom_range(20, 60);
        end
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word; give up
  // once the count reaches the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one byte after a random gap and hold it until the block takes it.
  // Valid is raised at a falling edge only, and the acceptance is seen at the
  // rising edge, so each step carries at most one update of in_valid.
  task automatic push_byte(input logic [7:0] b);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 98) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent++;
  endtask

  // Send marker, frame_body and check byte; optionally spoil marker or CRC.
  task automatic send_frame(input bit good_mark, input bit good_crc);
    logic [7:0] head;
    logic [7:0] crc;
    head = START_MARK;
    crc  = CRC_INIT;
    if (!good_mark) begin
      head = 8'($urandom);
      if (head == START_MARK) begin
        head = ~head;
      end
    end
    push_byte(head);
    for (int i = 0; i < LAST_PAY; i++) begin
      crc = crc8_byte(crc, frame_body[i]);
      push_byte(frame_body[i]);
    end
    if (!good_crc) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(crc);
  endtask

  // Hold the sender until every payload word already owed has come out.
  task automatic drain_payload();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_due != 0) begin
      @(negedge clk);
    end
  endtask

  // Pick a byte with the marker and the extremes well represented.
  function automatic logic [7:0] biased_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return START_MARK;
    end else if (r < 18) begin
      return 8'h00;
    end else if (r < 24) begin
      return 8'hff;
    end
    return 8'($urandom);
  endfunction

  initial begin : stimulus
    logic [7:0] loose_bytes [10];
    int         r;
    int         noise;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A clean frame straight after reset: the fill count reaches the frame
    // length on its very last byte. The payload carries the byte extremes and
    // markers inside the body, which must not be taken as frame starts.
    frame_body = '{8'h00, 8'hff, 8'hdd, 8'h55, 8'haa, 8'h01, 8'h80,
                   8'h7f, 8'hfe, 8'hdd, 8'hdd, 8'h00, 8'hff};
    send_frame(1'b1, 1'b1);

    // Markers and extremes while the window refills: no frame test can pass.
    loose_bytes = '{8'hdd, 8'h00, 8'hff, 8'hdd, 8'h07, 8'hdd, 8'h80, 8'h01,
                    8'hdd, 8'hff};
    foreach (loose_bytes[i]) begin
      push_byte(loose_bytes[i]);
    end
    drain_payload();

    // Random part: mostly well-formed frames with random bodies, some with a
    // spoilt marker or check byte, often led in by noise so that the fill
    // count saturates and stray markers get tried as frame starts.
    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        noise = $urandom_range(1, 20);
        repeat (noise) push_byte(biased_byte());
      end
      foreach (frame_body[i]) begin
        frame_body[i] = biased_byte();
      end
      r = $urandom_range(0, 99);
      send_frame(!(r >= 8 && r < 15), !(r < 8));
      if ($urandom_range(0, 19) == 0) begin
        drain_payload();
      end
    end

    // Drop valid, wait for every owed word, then let the block settle.
    drain_payload();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
